### hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define APR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Signal must be low in the cycle after reset is applied.
`define APR_ASSERT_RST(lbl, clk, rst_n, sig, msg) \
    lbl: assert property (@(posedge clk) !rst_n |=> !sig) \
        else $error(msg);

`endif

### hw/rtl/apr_pkg.sv
package apr_pkg;

    // Default geometry
    localparam int FRAMES_DEF    = 16;
    localparam int AGE_BITS_DEF  = 32;
    localparam int PAGE_BITS_DEF = 16;

    // Fixed field widths of the stream words
    localparam int PAGE_IN_W   = 16;
    localparam int FRAME_OUT_W = 4;
    localparam int EVPAGE_W    = 16;
    localparam int COUNT_W     = 32;
    localparam int OUT_USED_W  = 1 + FRAME_OUT_W + 1 + EVPAGE_W + 2 * COUNT_W;
    localparam int OUT_DATA_W  = ((OUT_USED_W + 7) / 8) * 8;

    // Bit positions in the result word
    localparam int OUT_HIT_POS   = 0;
    localparam int OUT_EVICT_POS = 1 + FRAME_OUT_W;

    // Flags of the search token walking the cell chain
    typedef struct packed {
        logic valid;
        logic hit;    // a cell upstream holds the page
        logic empty;  // a cell upstream is empty
    } t_tok_flags;

    // Update broadcast to all cells
    typedef struct packed {
        logic en;     // shift all ages, mark the chosen slot
        logic load;   // write the page tag into the chosen slot
    } t_upd;

endpackage

### hw/rtl/apr_cell.sv
// One frame: page tag and age, plus one stage of the search token.
module apr_cell #(
    parameter int FRAMES    = apr_pkg::FRAMES_DEF,
    parameter int AGE_BITS  = apr_pkg::AGE_BITS_DEF,
    parameter int PAGE_BITS = apr_pkg::PAGE_BITS_DEF,
    parameter int CELL_IDX  = 0,
    localparam int IDX_W    = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // token from the previous cell
    input  apr_pkg::t_tok_flags  i_flags,
    input  logic [PAGE_BITS-1:0] i_page,
    input  logic [IDX_W-1:0]     i_hit_idx,
    input  logic [IDX_W-1:0]     i_empty_idx,
    input  logic [AGE_BITS-1:0]  i_min_age,
    input  logic [IDX_W-1:0]     i_min_idx,
    input  logic [PAGE_BITS-1:0] i_min_tag,
    // token to the next cell
    output apr_pkg::t_tok_flags  o_flags,
    output logic [PAGE_BITS-1:0] o_page,
    output logic [IDX_W-1:0]     o_hit_idx,
    output logic [IDX_W-1:0]     o_empty_idx,
    output logic [AGE_BITS-1:0]  o_min_age,
    output logic [IDX_W-1:0]     o_min_idx,
    output logic [PAGE_BITS-1:0] o_min_tag,
    // update broadcast
    input  apr_pkg::t_upd        i_upd,
    input  logic [IDX_W-1:0]     i_upd_slot,
    input  logic [PAGE_BITS-1:0] i_upd_page
);

    localparam logic [IDX_W-1:0]    MY_IDX  = IDX_W'(CELL_IDX);
    localparam logic [AGE_BITS-1:0] AGE_TOP = {1'b1, {(AGE_BITS-1){1'b0}}};

    logic [PAGE_BITS-1:0] r_tag;
    logic [AGE_BITS-1:0]  r_age;

    apr_pkg::t_tok_flags  r_flags;
    logic [PAGE_BITS-1:0] r_page;
    logic [IDX_W-1:0]     r_hit_idx;
    logic [IDX_W-1:0]     r_empty_idx;
    logic [AGE_BITS-1:0]  r_min_age;
    logic [IDX_W-1:0]     r_min_idx;
    logic [PAGE_BITS-1:0] r_min_tag;

    logic [AGE_BITS-1:0]  w_age_sh;
    logic                 w_is_hit;
    logic                 w_is_empty;
    logic                 w_take_min;
    logic                 w_sel;

    // compare against this frame; ages are judged after the shift
    assign w_age_sh   = r_age >> 1;
    assign w_is_hit   = (r_tag == i_page);
    assign w_is_empty = (r_tag == '0);
    assign w_take_min = (CELL_IDX == 0) || (w_age_sh < i_min_age);
    assign w_sel      = (i_upd_slot == MY_IDX);

    // token stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else begin
            r_flags.valid <= i_flags.valid;
            r_flags.hit   <= i_flags.hit | w_is_hit;
            r_flags.empty <= i_flags.empty | w_is_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        r_page      <= i_page;
        r_hit_idx   <= (!i_flags.hit && w_is_hit) ? MY_IDX : i_hit_idx;
        r_empty_idx <= (!i_flags.empty && w_is_empty) ? MY_IDX : i_empty_idx;
        if (w_take_min) begin
            r_min_age <= w_age_sh;
            r_min_idx <= MY_IDX;
            r_min_tag <= r_tag;
        end else begin
            r_min_age <= i_min_age;
            r_min_idx <= i_min_idx;
            r_min_tag <= i_min_tag;
        end
    end

    // frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
            r_age <= '0;
        end else if (i_upd.en) begin
            r_age <= w_sel ? (w_age_sh | AGE_TOP) : w_age_sh;
            if (w_sel && i_upd.load) begin
                r_tag <= i_upd_page;
            end
        end
    end

    assign o_flags     = r_flags;
    assign o_page      = r_page;
    assign o_hit_idx   = r_hit_idx;
    assign o_empty_idx = r_empty_idx;
    assign o_min_age   = r_min_age;
    assign o_min_idx   = r_min_idx;
    assign o_min_tag   = r_min_tag;

endmodule

### hw/rtl/aging_page_replacement.sv
// Channel   Dir  Handshake                Word
// s (ref)   in   i_s_tvalid/o_s_tready    i_s_tdata[15:0] page
// m (res)   out  o_m_tvalid/i_m_tready    o_m_tdata: hit, frame, evicted,
//                                         evicted_page, hit_total, miss_total
//
// A reference is taken only when idle. The token walks the cell chain one frame
// per cycle, starting on the accept edge; the decision is then latched, and the
// commit writes the frames and the result register. No new reference is taken
// until the commit is done. A page of zero is accepted and dropped. Reset is
// synchronous, active low; it empties all frames and clears counts. A stalled
// result holds the commit.
`include "assert_macros.svh"

module aging_page_replacement #(
    parameter int FRAMES    = apr_pkg::FRAMES_DEF,
    parameter int AGE_BITS  = apr_pkg::AGE_BITS_DEF,
    parameter int PAGE_BITS = apr_pkg::PAGE_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // [15:0] page
    input  logic [apr_pkg::PAGE_IN_W-1:0]  i_s_tdata,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // [0] hit, [4:1] frame, [5] evicted, [21:6] evicted_page,
    // [53:22] hit_total, [85:54] miss_total, [87:86] zero
    output logic [apr_pkg::OUT_DATA_W-1:0] o_m_tdata
);

    localparam int IDX_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int COUNT_W = apr_pkg::COUNT_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_COMMIT
    } t_state;

    t_state r_state;

    // token links between cells
    apr_pkg::t_tok_flags  w_flags     [0:FRAMES];
    logic [PAGE_BITS-1:0] w_page      [0:FRAMES];
    logic [IDX_W-1:0]     w_hit_idx   [0:FRAMES];
    logic [IDX_W-1:0]     w_empty_idx [0:FRAMES];
    logic [AGE_BITS-1:0]  w_min_age   [0:FRAMES];
    logic [IDX_W-1:0]     w_min_idx   [0:FRAMES];
    logic [PAGE_BITS-1:0] w_min_tag   [0:FRAMES];

    apr_pkg::t_upd        w_upd;
    logic [IDX_W-1:0]     w_slot;

    // latched search result
    logic                 r_hit;
    logic                 r_empty;
    logic [IDX_W-1:0]     r_hit_idx;
    logic [IDX_W-1:0]     r_empty_idx;
    logic [IDX_W-1:0]     r_min_idx;
    logic [PAGE_BITS-1:0] r_min_tag;
    logic [PAGE_BITS-1:0] r_page;

    logic [COUNT_W-1:0]   r_hits;
    logic [COUNT_W-1:0]   r_misses;
    logic [COUNT_W-1:0]   n_hits;
    logic [COUNT_W-1:0]   n_misses;

    logic                 r_m_valid;
    logic [apr_pkg::OUT_DATA_W-1:0] r_m_data;
    logic [apr_pkg::OUT_DATA_W-1:0] n_m_data;

    logic                 w_accept;
    logic [PAGE_BITS-1:0] w_in_page;
    logic                 w_out_free;
    logic                 w_evict;
    logic [PAGE_BITS-1:0] w_ev_page;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && (r_state == S_IDLE);
    assign w_in_page  = PAGE_BITS'(i_s_tdata);
    assign w_out_free = !r_m_valid || i_m_tready;

    // token injection into the first cell
    assign w_flags[0].valid = w_accept && (w_in_page != '0);
    assign w_flags[0].hit   = 1'b0;
    assign w_flags[0].empty = 1'b0;
    assign w_page[0]        = w_in_page;
    assign w_hit_idx[0]     = '0;
    assign w_empty_idx[0]   = '0;
    assign w_min_age[0]     = '0;
    assign w_min_idx[0]     = '0;
    assign w_min_tag[0]     = '0;

    // cell chain
    for (genvar g = 0; g < FRAMES; g++) begin : g_cell
        apr_cell #(
            .FRAMES    (FRAMES),
            .AGE_BITS  (AGE_BITS),
            .PAGE_BITS (PAGE_BITS),
            .CELL_IDX  (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_flags     (w_flags[g]),
            .i_page      (w_page[g]),
            .i_hit_idx   (w_hit_idx[g]),
            .i_empty_idx (w_empty_idx[g]),
            .i_min_age   (w_min_age[g]),
            .i_min_idx   (w_min_idx[g]),
            .i_min_tag   (w_min_tag[g]),
            .o_flags     (w_flags[g+1]),
            .o_page      (w_page[g+1]),
            .o_hit_idx   (w_hit_idx[g+1]),
            .o_empty_idx (w_empty_idx[g+1]),
            .o_min_age   (w_min_age[g+1]),
            .o_min_idx   (w_min_idx[g+1]),
            .o_min_tag   (w_min_tag[g+1]),
            .i_upd       (w_upd),
            .i_upd_slot  (w_slot),
            .i_upd_page  (r_page)
        );
    end

    // replacement decision: hit frame, else first empty, else oldest
    assign w_slot    = r_hit ? r_hit_idx : (r_empty ? r_empty_idx : r_min_idx);
    assign w_evict   = !r_hit && !r_empty;
    assign w_ev_page = w_evict ? r_min_tag : '0;

    assign w_upd.en   = (r_state == S_COMMIT) && w_out_free;
    assign w_upd.load = !r_hit;

    // saturating totals
    assign n_hits   = (r_hit && (r_hits != '1)) ? r_hits + 1'b1 : r_hits;
    assign n_misses = (!r_hit && (r_misses != '1)) ? r_misses + 1'b1 : r_misses;

    assign n_m_data = {
        (apr_pkg::OUT_DATA_W - apr_pkg::OUT_USED_W)'(0),
        n_misses,
        n_hits,
        apr_pkg::EVPAGE_W'(w_ev_page),
        w_evict,
        apr_pkg::FRAME_OUT_W'(w_slot),
        r_hit
    };

    // control and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
            r_hits    <= '0;
            r_misses  <= '0;
        end else begin
            // result valid: set on commit, cleared when taken
            if (r_state == S_COMMIT && w_out_free) begin
                r_m_valid <= 1'b1;
            end else if (r_m_valid && i_m_tready) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_flags[0].valid) begin
                        r_state <= S_SEARCH;
                    end
                end
                S_SEARCH: begin
                    if (w_flags[FRAMES].valid) begin
                        r_state <= S_COMMIT;
                    end
                end
                S_COMMIT: begin
                    if (w_out_free) begin
                        r_state   <= S_IDLE;
                        r_hits    <= n_hits;
                        r_misses  <= n_misses;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // search result and word payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_SEARCH && w_flags[FRAMES].valid) begin
            r_hit       <= w_flags[FRAMES].hit;
            r_empty     <= w_flags[FRAMES].empty;
            r_hit_idx   <= w_hit_idx[FRAMES];
            r_empty_idx <= w_empty_idx[FRAMES];
            r_min_idx   <= w_min_idx[FRAMES];
            r_min_tag   <= w_min_tag[FRAMES];
            r_page      <= w_page[FRAMES];
        end
        if (w_upd.en) begin
            r_m_data <= n_m_data;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

    // checks
    `APR_ASSERT(a_tok_in_search, i_clk, i_rst_n,
        w_flags[FRAMES].valid |-> (r_state == S_SEARCH), "token left chain outside search")
    `APR_ASSERT(a_upd_no_tok, i_clk, i_rst_n,
        w_upd.en |-> !w_flags[0].valid, "update collides with a new token")
    `APR_ASSERT(a_hit_no_evict, i_clk, i_rst_n,
        (r_m_valid && r_m_data[apr_pkg::OUT_HIT_POS]) |-> !r_m_data[apr_pkg::OUT_EVICT_POS],
        "hit reported with eviction")
    `APR_ASSERT(a_count_idle, i_clk, i_rst_n,
        (r_state == S_IDLE) |=> ((r_hits == $past(r_hits)) && (r_misses == $past(r_misses))),
        "totals moved without a commit")
    `APR_ASSERT_RST(a_rst_out, i_clk, i_rst_n, o_m_tvalid, "result valid after reset")

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int PAGE_IN_W     = apr_pkg::PAGE_IN_W;
    localparam int FRAME_OUT_W   = apr_pkg::FRAME_OUT_W;
    localparam int EVPAGE_W      = apr_pkg::EVPAGE_W;
    localparam int COUNT_W       = apr_pkg::COUNT_W;
    localparam int OUT_DATA_W    = apr_pkg::OUT_DATA_W;
    localparam int OUT_HIT_POS   = apr_pkg::OUT_HIT_POS;
    localparam int OUT_EVICT_POS = apr_pkg::OUT_EVICT_POS;
    localparam int NFRAMES     = apr_pkg::FRAMES_DEF;
    localparam int FRAME_POS   = OUT_HIT_POS + 1;
    localparam int EVPAGE_POS  = OUT_EVICT_POS + 1;
    localparam int HITS_POS    = EVPAGE_POS + EVPAGE_W;
    localparam int MISSES_POS  = HITS_POS + COUNT_W;
    localparam int RANDOM_REFS = 1300;
    localparam int STALL_LIMIT = 1000;
    localparam int DRAIN_WAIT  = 2 * (NFRAMES + 2) + 4;
    localparam int LONG_HOLD   = 250;

    // One result word, split into its fields
    typedef struct packed {
        bit                   hit;
        bit [FRAME_OUT_W-1:0] frame;
        bit                   evicted;
        bit [EVPAGE_W-1:0]    evicted_page;
        bit [COUNT_W-1:0]     hit_total;
        bit [COUNT_W-1:0]     miss_total;
    } t_lookup;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [PAGE_IN_W-1:0]  i_s_tdata = '0;  // [15:0] page
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    // [0] hit, [4:1] frame, [5] evicted, [21:6] evicted_page,
    // [53:22] hit_total, [85:54] miss_total, [87:86] zero
    logic [OUT_DATA_W-1:0] o_m_tdata;

    aging_page_replacement i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #2 i_clk = ~i_clk;

    // Predictor state: resident pages, ages, running totals
    bit [PAGE_IN_W-1:0] resident_tag [NFRAMES];
    bit [31:0]          resident_age [NFRAMES];
    bit [COUNT_W-1:0]   hits_so_far;
    bit [COUNT_W-1:0]   misses_so_far;

    bit [PAGE_IN_W-1:0] pending_pages [$];
    t_lookup            expected_results [$];

    int  err_count;
    int  words_in;
    int  words_out;
    int  words_taken;
    int  zeros_dropped;
    int  n_hits;
    int  n_misses;
    int  n_evictions;
    int  n_ties;
    int  idle_cycles;

    // Apply one reference to the predictor; returns 0 when the page is dropped
    function automatic bit predict_reference(input bit [PAGE_IN_W-1:0] page,
                                             output t_lookup res);
        int slot;
        int n_oldest;
        res = '0;
        if (page == '0) begin
            return 1'b0;
        end
        for (int i = 0; i < NFRAMES; i++) begin
            resident_age[i] = resident_age[i] >> 1;
        end
        slot = -1;
        for (int i = 0; i < NFRAMES; i++) begin
            if (slot < 0 && resident_tag[i] == page) slot = i;
        end
        if (slot >= 0) begin
            res.hit = 1'b1;
            if (hits_so_far != '1) hits_so_far++;
        end else begin
            if (misses_so_far != '1) misses_so_far++;
            for (int i = 0; i < NFRAMES; i++) begin
                if (slot < 0 && resident_tag[i] == '0) slot = i;
            end
            if (slot < 0) begin
                // no free frame: first frame holding the smallest age
                slot = 0;
                for (int i = 1; i < NFRAMES; i++) begin
                    if (resident_age[i] < resident_age[slot]) slot = i;
                end
                n_oldest = 0;
                for (int i = 0; i < NFRAMES; i++) begin
                    if (resident_age[i] == resident_age[slot]) n_oldest++;
                end
                if (n_oldest > 1) n_ties++;
                res.evicted      = 1'b1;
                res.evicted_page = resident_tag[slot];
                n_evictions++;
            end
            resident_tag[slot] = page;
        end
        resident_age[slot][31] = 1'b1;
        res.frame      = slot[FRAME_OUT_W-1:0];
        res.hit_total  = hits_so_far;
        res.miss_total = misses_so_far;
        if (res.hit) n_hits++;
        else n_misses++;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string field, input longint unsigned got,
                                   input longint unsigned want);
        $display("[%0t] word %0d: %s is 0x%0h, want 0x%0h", $time, words_out, field,
                 got, want);
        err_count++;
    endtask

    // Sample both handshakes at the rising edge
    always @(posedge i_clk) begin
        t_lookup got;
        t_lookup want;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                words_in++;
                if (predict_reference(i_s_tdata, want)) expected_results.push_back(want);
                else zeros_dropped++;
            end
            if (o_m_tvalid && i_m_tready) begin
                got.hit          = o_m_tdata[OUT_HIT_POS];
                got.frame        = o_m_tdata[FRAME_POS +: FRAME_OUT_W];
                got.evicted      = o_m_tdata[OUT_EVICT_POS];
                got.evicted_page = o_m_tdata[EVPAGE_POS +: EVPAGE_W];
                got.hit_total    = o_m_tdata[HITS_POS +: COUNT_W];
                got.miss_total   = o_m_tdata[MISSES_POS +: COUNT_W];
                if (expected_results.size() == 0) begin
                    $display("[%0t] result word with no reference pending", $time);
                    err_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.hit != want.hit) report_mismatch("hit", got.hit, want.hit);
                    if (got.frame != want.frame)
                        report_mismatch("frame", got.frame, want.frame);
                    if (got.evicted != want.evicted)
                        report_mismatch("evicted", got.evicted, want.evicted);
                    if (got.evicted_page != want.evicted_page)
                        report_mismatch("evicted_page", got.evicted_page, want.evicted_page);
                    if (got.hit_total != want.hit_total)
                        report_mismatch("hit_total", got.hit_total, want.hit_total);
                    if (got.miss_total != want.miss_total)
                        report_mismatch("miss_total", got.miss_total, want.miss_total);
                end
                words_out++;
            end
            // watchdog on stretches without any handshake
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= STALL_LIMIT) begin
                    $display("[%0t] no handshake for %0d cycles", $time, STALL_LIMIT);
                    $display("aging_page_replacement regression: fail");
                    $finish;
                end
            end
        end
    end

    // Reference driver: advances after each accepted word, random gap bursts
    int send_gap;
    always @(negedge i_clk) begin
        logic                 nxt_valid;
        logic [PAGE_IN_W-1:0] nxt_data;
        nxt_valid = i_s_tvalid;
        nxt_data  = i_s_tdata;
        if (i_rst_n && (!i_s_tvalid || words_taken != words_in)) begin
            words_taken = words_in;
            nxt_valid   = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
            end else if (pending_pages.size() > 0) begin
                nxt_valid = 1'b1;
                nxt_data  = pending_pages.pop_front();
                if (pending_pages.size() > 150 && $urandom_range(0, 5) == 0)
                    send_gap = $urandom_range(1, 19);
            end
        end
        i_s_tvalid <= nxt_valid;
        i_s_tdata  <= nxt_data;
    end

    // Result sink: random stall bursts plus one long hold-off
    int  sink_stall;
    int  hold_left;
    bit  hold_done;
    always @(negedge i_clk) begin
        logic nxt_ready;
        nxt_ready = 1'b1;
        if (!i_rst_n) begin
            nxt_ready = 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            nxt_ready = 1'b0;
        end else if (!hold_done && words_out >= 300) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD - 1;
            nxt_ready = 1'b0;
        end else if (sink_stall > 0) begin
            sink_stall--;
            nxt_ready = 1'b0;
        end else if (pending_pages.size() > 150 && $urandom_range(0, 4) == 0) begin
            sink_stall = $urandom_range(0, 18);
            nxt_ready  = 1'b0;
        end
        i_m_tready <= nxt_ready;
    end

    // Stimulus and end of run
    initial begin
        bit [PAGE_IN_W-1:0] pool [24];
        bit [PAGE_IN_W-1:0] pg;
        int n_random;
        int pick;
        int run_len;

        // directed: extremes, a dropped zero, hits, fill-up, evictions
        pending_pages.push_back(16'h0001);
        pending_pages.push_back(16'hFFFF);
        pending_pages.push_back(16'h0000);
        pending_pages.push_back(16'h0001);
        pending_pages.push_back(16'hFFFF);
        for (int k = 1; k < 15; k++) pending_pages.push_back(16'h0001 << k);
        pending_pages.push_back(16'h8000);
        pending_pages.push_back(16'h0001);
        pending_pages.push_back(16'hAAAA);
        pending_pages.push_back(16'h5555);

        // random: mostly a small working set so hits and evictions both happen
        n_random = 0;
        while (n_random < RANDOM_REFS) begin
            if (n_random % 200 == 0) begin
                foreach (pool[i]) pool[i] = PAGE_IN_W'($urandom_range(1, 65535));
            end
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                pending_pages.push_back(pool[$urandom_range(0, 23)]);
                n_random++;
            end else if (pick < 78) begin
                // one page hammered long enough for other ages to reach zero
                pg      = pool[$urandom_range(0, 23)];
                run_len = $urandom_range(33, 40);
                repeat (run_len) pending_pages.push_back(pg);
                n_random += run_len;
            end else if (pick < 90) begin
                pending_pages.push_back(PAGE_IN_W'($urandom_range(1, 65535)));
                n_random++;
            end else if (pick < 95) begin
                pending_pages.push_back(16'h0000);
            end else begin
                case ($urandom_range(0, 2))
                    0: pending_pages.push_back(16'hFFFF);
                    1: pending_pages.push_back(16'h0001);
                    default: pending_pages.push_back(16'h0001 << $urandom_range(0, 15));
                endcase
                n_random++;
            end
        end

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_pages.size() == 0 && !i_s_tvalid);
        wait (expected_results.size() == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("covered %0d references (%0d zero pages dropped), %0d results checked",
                 words_in, zeros_dropped, words_out);
        $display("%0d hits, %0d misses, %0d evictions, %0d with tied oldest ages",
                 n_hits, n_misses, n_evictions, n_ties);
        if (err_count == 0) begin
            $display("aging_page_replacement regression: pass");
        end else begin
            $display("aging_page_replacement regression: fail");
        end
        $finish;
    end

endmodule
